### rtl/ckrs_pkg.sv
// Package: shared constants, codes and types of the consecutive k-mer repeat scorer.
`default_nettype none
package ckrs_pkg;

	localparam int K_MAX_DEF       = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int BASE_W     = 8;
	localparam int FRAME_W    = 3;
	localparam int SCORE_W    = 16;
	localparam int BCOUNT_W   = 16;
	localparam int KLEN_W     = 4;
	localparam int MODE_W     = 2;
	localparam int TARGET_W   = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KMER_LEN    = 3'd0,
		REG_SCORE_MODE  = 3'd1,
		REG_TARGET_KMER = 3'd2,
		REG_THRESHOLD   = 3'd3,
		REG_MAX_LEN     = 3'd4,
		REG_USE_MAX_LEN = 3'd5
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ACC = 2'd0,
		MODE_RUN = 2'd1,
		MODE_TGT = 2'd2
	} mode_t;

	// block comparison results for the current transfer
	typedef struct packed {
		logic same;     // new block equals the previous one
		logic hit_old;  // stored previous block equals the target
		logic hit_new;  // previous block after this transfer equals the target
	} match_t;

	// per-transfer control from the sequence tracker to the score unit
	typedef struct packed {
		logic step;  // transfer accepted
		logic cmp;   // a complete block is compared with its predecessor
		logic last;  // final base of the sequence
	} score_ctl_t;

endpackage
`default_nettype wire

### rtl/ckrs_block.sv
// Block store: current and previous k-mer bytes with equality and target compare.
`default_nettype none
module ckrs_block #(
	parameter int K_MAX = ckrs_pkg::K_MAX_DEF,
	parameter int KW    = $clog2(K_MAX + 1),
	parameter int PW    = (K_MAX > 1) ? $clog2(K_MAX) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          wr,
	input  wire logic                          adv,
	input  wire logic [PW-1:0]                 pos,
	input  wire logic [ckrs_pkg::BASE_W-1:0]   base,
	input  wire logic [KW-1:0]                 k,
	input  wire logic [ckrs_pkg::TARGET_W-1:0] target,
	output ckrs_pkg::match_t                   match
);
	import ckrs_pkg::*;

	logic [BASE_W-1:0] cur_q  [K_MAX];
	logic [BASE_W-1:0] prev_q [K_MAX];
	logic [BASE_W-1:0] cur_nxt[K_MAX];
	logic              same;
	logic              hit_old;
	logic              hit_cur;

	always_comb begin
		same    = 1'b1;
		hit_old = 1'b1;
		hit_cur = 1'b1;
		for (int j = 0; j < K_MAX; j++) begin
			cur_nxt[j] = (wr && pos == PW'(j)) ? base : cur_q[j];
			if (KW'(j) < k) begin
				if (prev_q[j] != cur_nxt[j])
					same = 1'b0;
				if (prev_q[j] != target[8*j +: 8])
					hit_old = 1'b0;
				if (cur_nxt[j] != target[8*j +: 8])
					hit_cur = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < K_MAX; j++) begin
			cur_q[j] <= cur_nxt[j];
			if (adv)
				prev_q[j] <= cur_nxt[j];
		end
	end

	assign match.same    = same;
	assign match.hit_old = hit_old;
	assign match.hit_new = adv ? hit_cur : hit_old;

endmodule
`default_nettype wire

### rtl/ckrs_close.sv
// Run closing: add run length plus one to acc and, on a hit, to tgt score.
`default_nettype none
module ckrs_close #(
	parameter int CW = ckrs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic [CW-1:0] run,
	input  wire logic [CW-1:0] acc,
	input  wire logic [CW-1:0] max_acc,
	input  wire logic [CW-1:0] tgt,
	input  wire logic [CW-1:0] max_tgt,
	input  wire logic          hit,
	output logic      [CW-1:0] acc_nxt,
	output logic      [CW-1:0] max_acc_nxt,
	output logic      [CW-1:0] tgt_nxt,
	output logic      [CW-1:0] max_tgt_nxt
);
	import ckrs_pkg::*;

	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	logic [CW:0]   add;
	logic [CW+1:0] acc_sum;
	logic [CW+1:0] tgt_sum;

	always_comb begin
		add     = {1'b0, run} + (CW+1)'(1);
		acc_sum = {2'b00, acc} + {1'b0, add};
		tgt_sum = {2'b00, tgt} + {1'b0, add};

		acc_nxt     = (acc_sum > (CW+2)'(CNT_MAX)) ? CNT_MAX : acc_sum[CW-1:0];
		max_acc_nxt = (acc_nxt > max_acc) ? acc_nxt : max_acc;

		tgt_nxt     = tgt;
		max_tgt_nxt = max_tgt;
		if (hit) begin
			tgt_nxt     = (tgt_sum > (CW+2)'(CNT_MAX)) ? CNT_MAX : tgt_sum[CW-1:0];
			max_tgt_nxt = (tgt_nxt > max_tgt) ? tgt_nxt : max_tgt;
		end else if ({1'b0, tgt} > add) begin
			// lower only while the score stays positive
			tgt_nxt = tgt - add[CW-1:0];
		end
	end

endmodule
`default_nettype wire

### rtl/ckrs_score.sv
// Score unit: run counter, three saturating scores with maxima, score selection.
`default_nettype none
module ckrs_score #(
	parameter int CW = ckrs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ckrs_pkg::score_ctl_t         ctl,
	input  wire ckrs_pkg::match_t             match,
	input  wire logic [ckrs_pkg::MODE_W-1:0]  mode,
	output logic      [ckrs_pkg::SCORE_W-1:0] score
);
	import ckrs_pkg::*;

	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
	localparam int            SW      = (CW + 1 > SCORE_W) ? CW + 1 : SCORE_W;

	logic [CW-1:0] run_q, max_run_q, acc_q, max_acc_q, tgt_q, max_tgt_q;

	// after the block compare
	logic [CW-1:0] run_a, max_run_a, acc_a, max_acc_a, tgt_a, max_tgt_a;
	// after the closing of a run at the last base
	logic [CW-1:0] acc_b, max_acc_b, tgt_b, max_tgt_b;

	logic [CW-1:0] c1_acc, c1_max_acc, c1_tgt, c1_max_tgt;
	logic [CW-1:0] c2_acc, c2_max_acc, c2_tgt, c2_max_tgt;
	logic          close_b;
	logic [SW-1:0] sel;

	ckrs_close #(.CW(CW)) u_close_blk (
		.run         (run_q),
		.acc         (acc_q),
		.max_acc     (max_acc_q),
		.tgt         (tgt_q),
		.max_tgt     (max_tgt_q),
		.hit         (match.hit_old),
		.acc_nxt     (c1_acc),
		.max_acc_nxt (c1_max_acc),
		.tgt_nxt     (c1_tgt),
		.max_tgt_nxt (c1_max_tgt)
	);

	always_comb begin
		run_a     = run_q;
		max_run_a = max_run_q;
		acc_a     = acc_q;
		max_acc_a = max_acc_q;
		tgt_a     = tgt_q;
		max_tgt_a = max_tgt_q;
		if (ctl.cmp) begin
			if (match.same) begin
				run_a     = (run_q == CNT_MAX) ? run_q : run_q + CW'(1);
				max_run_a = (run_a > max_run_q) ? run_a : max_run_q;
			end else if (run_q != '0) begin
				run_a     = '0;
				acc_a     = c1_acc;
				max_acc_a = c1_max_acc;
				tgt_a     = c1_tgt;
				max_tgt_a = c1_max_tgt;
			end else begin
				if (acc_q != '0)
					acc_a = acc_q - CW'(1);
				if (tgt_q != '0)
					tgt_a = tgt_q - CW'(1);
			end
		end
	end

	ckrs_close #(.CW(CW)) u_close_end (
		.run         (run_a),
		.acc         (acc_a),
		.max_acc     (max_acc_a),
		.tgt         (tgt_a),
		.max_tgt     (max_tgt_a),
		.hit         (match.hit_new),
		.acc_nxt     (c2_acc),
		.max_acc_nxt (c2_max_acc),
		.tgt_nxt     (c2_tgt),
		.max_tgt_nxt (c2_max_tgt)
	);

	always_comb begin
		close_b   = ctl.last && (run_a != '0);
		acc_b     = close_b ? c2_acc     : acc_a;
		max_acc_b = close_b ? c2_max_acc : max_acc_a;
		tgt_b     = close_b ? c2_tgt     : tgt_a;
		max_tgt_b = close_b ? c2_max_tgt : max_tgt_a;

		case (mode)
			MODE_ACC: sel = SW'(max_acc_b);
			MODE_RUN: sel = SW'({1'b0, max_run_a} + (CW+1)'(1));
			default:  sel = SW'(max_tgt_b);
		endcase
		score = (sel > SW'({SCORE_W{1'b1}})) ? {SCORE_W{1'b1}} : sel[SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= '0;
			max_run_q <= '0;
			acc_q     <= '0;
			max_acc_q <= '0;
			tgt_q     <= '0;
			max_tgt_q <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				run_q     <= '0;
				max_run_q <= '0;
				acc_q     <= '0;
				max_acc_q <= '0;
				tgt_q     <= '0;
				max_tgt_q <= '0;
			end else begin
				run_q     <= run_a;
				max_run_q <= max_run_a;
				acc_q     <= acc_b;
				max_acc_q <= max_acc_b;
				tgt_q     <= tgt_b;
				max_tgt_q <= max_tgt_b;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/consecutive_kmer_repeat_scorer.sv
// Top level: configuration registers, sequence tracking, result register.
//
// Takes one base per clock and updates the whole sequence state (frame skip,
// block position, block compare, run and score counters) in the same cycle,
// so a new base can follow every cycle with no gap between sequences. The
// result of a sequence, if emitted, appears in the output register in the cycle after the
// transfer of its last base. The input stalls only when a last base arrives
// while a previous result is still held in the output register and stalled;
// all other bases are taken while a result waits. The depth of the cycle is
// set by the block compare, the run update it selects and the closing of an
// open run at the last base, followed by score selection and the threshold
// compare; the run closing on a mismatch works from registered values in
// parallel with the compare. Configuration writes take effect at once, one
// register per cycle.
`default_nettype none
module consecutive_kmer_repeat_scorer #(
	parameter int K_MAX       = ckrs_pkg::K_MAX_DEF,
	parameter int COUNT_WIDTH = ckrs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ckrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ckrs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [ckrs_pkg::BASE_W-1:0]     base,
	input  wire logic [ckrs_pkg::FRAME_W-1:0]    frame,
	input  wire logic                            last,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [ckrs_pkg::SCORE_W-1:0]    score,
	output logic                                 too_long
);
	import ckrs_pkg::*;

	localparam int KW = $clog2(K_MAX + 1);
	localparam int PW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

	// configuration
	logic [KLEN_W-1:0]   kmer_len_q;
	logic [MODE_W-1:0]   score_mode_q;
	logic [TARGET_W-1:0] target_q;
	logic [SCORE_W-1:0]  threshold_q;
	logic [BCOUNT_W-1:0] max_len_q;
	logic                use_max_q;

	// sequence state
	logic                seq_start_q;
	logic [FRAME_W-1:0]  skip_q;
	logic [PW-1:0]       pos_q;
	logic [BCOUNT_W-1:0] bcount_q;
	logic                have_prev_q;
	logic                past_max_q;

	// result register
	logic                out_valid_q;
	logic [SCORE_W-1:0]  score_q;
	logic                too_long_q;

	logic                acc_in;
	logic [KW-1:0]       k;
	logic [FRAME_W-1:0]  skip_eff;
	logic [FRAME_W-1:0]  skip_nxt;
	logic                beyond;
	logic                hold;
	logic                active;
	logic [PW:0]         pos_inc;
	logic                blk_done;
	logic [PW-1:0]       pos_nxt;
	logic [BCOUNT_W-1:0] bcount_nxt;
	logic                past_nxt;
	logic                long_enough;
	logic                emit;
	logic [SCORE_W-1:0]  score_sel;
	match_t              match;
	score_ctl_t          ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q   <= KLEN_W'(3);
			score_mode_q <= MODE_ACC;
			target_q     <= '0;
			threshold_q  <= '0;
			max_len_q    <= '1;
			use_max_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KMER_LEN:    kmer_len_q   <= cfg_data[KLEN_W-1:0];
				REG_SCORE_MODE:  score_mode_q <= cfg_data[MODE_W-1:0];
				REG_TARGET_KMER: target_q     <= cfg_data[TARGET_W-1:0];
				REG_THRESHOLD:   threshold_q  <= cfg_data[SCORE_W-1:0];
				REG_MAX_LEN:     max_len_q    <= cfg_data[BCOUNT_W-1:0];
				REG_USE_MAX_LEN: use_max_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a last base is held back only while an undelivered result is stalled
	assign in_stall = out_valid_q && out_stall && last;
	assign acc_in   = in_valid && !in_stall;

	always_comb begin
		if (kmer_len_q == '0)
			k = KW'(1);
		else if (kmer_len_q > KLEN_W'(K_MAX))
			k = KW'(K_MAX);
		else
			k = KW'(kmer_len_q);

		skip_eff = seq_start_q ? frame : skip_q;
		beyond   = bcount_q >= max_len_q;
		hold     = beyond && use_max_q;
		active   = !hold && (skip_eff == '0);
		skip_nxt = (!hold && skip_eff != '0) ? skip_eff - FRAME_W'(1) : skip_eff;

		pos_inc  = {1'b0, pos_q} + (PW+1)'(1);
		blk_done = active && ((PW+KW+1)'(pos_inc) >= (PW+KW+1)'(k));
		if (blk_done)
			pos_nxt = '0;
		else if (active)
			pos_nxt = pos_inc[PW-1:0];
		else
			pos_nxt = pos_q;

		bcount_nxt  = (bcount_q == '1) ? bcount_q : bcount_q + BCOUNT_W'(1);
		past_nxt    = past_max_q || beyond;
		long_enough = bcount_nxt >= BCOUNT_W'({k, 1'b0});
		emit        = acc_in && last && long_enough && (score_sel >= threshold_q);

		ctl.step = acc_in;
		ctl.cmp  = blk_done && have_prev_q;
		ctl.last = last;
	end

	ckrs_block #(.K_MAX(K_MAX), .KW(KW), .PW(PW)) u_block (
		.clk    (clk),
		.wr     (acc_in && active),
		.adv    (acc_in && blk_done),
		.pos    (pos_q),
		.base   (base),
		.k      (k),
		.target (target_q),
		.match  (match)
	);

	ckrs_score #(.CW(COUNT_WIDTH)) u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.match  (match),
		.mode   (score_mode_q),
		.score  (score_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_start_q <= 1'b1;
			skip_q      <= '0;
			pos_q       <= '0;
			bcount_q    <= '0;
			have_prev_q <= 1'b0;
			past_max_q  <= 1'b0;
		end else if (acc_in) begin
			if (last) begin
				seq_start_q <= 1'b1;
				skip_q      <= '0;
				pos_q       <= '0;
				bcount_q    <= '0;
				have_prev_q <= 1'b0;
				past_max_q  <= 1'b0;
			end else begin
				seq_start_q <= 1'b0;
				skip_q      <= skip_nxt;
				pos_q       <= pos_nxt;
				bcount_q    <= bcount_nxt;
				have_prev_q <= have_prev_q || blk_done;
				past_max_q  <= past_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			score_q    <= score_sel;
			too_long_q <= past_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign score     = score_q;
	assign too_long  = too_long_q;

	// a new result only follows the transfer of a last base
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_valid && !in_stall && last))
		else $error("result without a last base");

	// every accepted last base rearms the frame sampling
	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last) |=> seq_start_q)
		else $error("sequence state not cleared after last base");

	// skipped bases never advance the block position
	a_skip_holds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !last && !seq_start_q && skip_q != '0)
			|=> (pos_q == $past(pos_q)))
		else $error("block position moved during frame skip");

	// a stalled result is never overwritten by a new one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("pending result overwritten");

endmodule
`default_nettype wire
